// ===== hdl/ps2_mouse_cursor_tracker_assert.svh =====
// Assertion macros used by the checker file of the PS/2 cursor tracker.
`ifndef PS2_MOUSE_CURSOR_TRACKER_ASSERT_SVH
`define PS2_MOUSE_CURSOR_TRACKER_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define PS2MCT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ps2 cursor tracker: same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define PS2MCT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ps2 cursor tracker: next-cycle check failed");

`endif

// ===== hdl/ps2mct_pkg.sv =====
// Package with the types, constants and helper functions of the PS/2 cursor tracker.
package ps2mct_pkg;

    localparam int unsigned COORD_W   = 12;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned SUM_W     = COORD_W + 2;
    localparam int unsigned RESULT_W  = 2 * COORD_W + 2 * BYTE_W + 2;
    localparam int unsigned TDATA_W   = ((RESULT_W + 7) / 8) * 8;

    localparam int unsigned SYNC_BIT  = 3;
    localparam int unsigned LEFT_BIT  = 0;

    localparam logic [COORD_W-1:0] MAX_X_RESET = COORD_W'(1264);
    localparam logic [COORD_W-1:0] MAX_Y_RESET = COORD_W'(1008);

    // Bit positions of the result fields inside m_axis_tdata.
    localparam int unsigned POS_CURSOR_X     = 0;
    localparam int unsigned POS_CURSOR_Y     = POS_CURSOR_X + COORD_W;
    localparam int unsigned POS_DELTA_X      = POS_CURSOR_Y + COORD_W;
    localparam int unsigned POS_DELTA_Y      = POS_DELTA_X + BYTE_W;
    localparam int unsigned POS_LEFT_BUTTON  = POS_DELTA_Y + BYTE_W;
    localparam int unsigned POS_LEFT_PRESSED = POS_LEFT_BUTTON + 1;

    // Configuration register indexes.
    typedef enum logic {
        CFG_MAX_X = 1'b0,
        CFG_MAX_Y = 1'b1
    } ps2mct_cfg_idx_t;

    // Packet assembly state: which packet byte is expected next.
    typedef enum logic [1:0] {
        WAIT_HEADER = 2'd0,
        WAIT_X      = 2'd1,
        WAIT_Y      = 2'd2
    } ps2mct_state_t;

    // Result item, cursor_x in the lowest bits.
    typedef struct packed {
        logic                      left_pressed;
        logic                      left_held;
        logic signed [BYTE_W-1:0]  delta_y;
        logic signed [BYTE_W-1:0]  delta_x;
        logic [COORD_W-1:0]        cursor_y;
        logic [COORD_W-1:0]        cursor_x;
    } ps2mct_result_t;

    // Clamps a signed, widened coordinate to the range 0..lim.
    function automatic logic [COORD_W-1:0] clamp_axis(
        input logic signed [SUM_W-1:0] v,
        input logic [COORD_W-1:0]      lim
    );
        logic [COORD_W-1:0] res;
        if (v < 0)
        begin
            res = '0;
        end
        else if (v[SUM_W-2:0] > {1'b0, lim})
        begin
            res = lim;
        end
        else
        begin
            res = v[COORD_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== hdl/ps2_mouse_cursor_tracker.sv =====
// Top level of the PS/2 mouse cursor tracker: packet assembly, cursor update and clamp.

// The block takes one byte per cycle from a PS/2 controller on the s_axis side; bytes
// whose tuser flag is low came from the keyboard port and are dropped without effect.
// Mouse bytes are gathered into three-byte packets (header, X movement, Y movement);
// a header without its sync bit (bit 3) is dropped so the decoder falls back into
// step. On the third byte the signed X delta is added to the cursor and the signed Y
// delta subtracted, each axis clamped to 0..limit, and one result transfer goes out
// on m_axis with the new cursor, both deltas, the left button and a flag for its
// press. The limits are written through the cfg port (index 0 for x, index 1 for y)
// and reset to 1264 and 1008; write them only while no byte is in flight. A byte
// passes an input register and the decode/update logic into the result register, which
// drives m_axis_tvalid. A new byte is taken every cycle; only a third byte that finds
// the result register still full waits, and then s_axis_tready drops until the result
// is taken.
module ps2_mouse_cursor_tracker
    import ps2mct_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    // Controller bytes in.
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,   // [7:0] rx_byte
    input  logic                s_axis_tuser,   // [0] from_aux

    // Cursor reports out.
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // [11:0] cursor_x, [23:12] cursor_y, [31:24] delta_x, [39:32] delta_y,
    // [40] left_held, [41] left_pressed, [47:42] zero
    output logic [TDATA_W-1:0]  m_axis_tdata,

    // Configuration writes.
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [COORD_W-1:0]  cfg_data
);

    // Input register.
    logic                 in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0]    in_byte_reg;
    logic                 in_aux_reg;

    // Packet and cursor state.
    ps2mct_state_t        state_reg, state_next;
    logic [BYTE_W-1:0]    header_reg, header_next;
    logic [BYTE_W-1:0]    x_move_reg, x_move_next;
    logic [COORD_W-1:0]   pos_x_reg, pos_x_next;
    logic [COORD_W-1:0]   pos_y_reg, pos_y_next;
    logic                 prev_left_reg, prev_left_next;

    // Clamp limits.
    logic [COORD_W-1:0]   max_x_reg;
    logic [COORD_W-1:0]   max_y_reg;

    // Result register.
    logic                 out_valid_reg, out_valid_next;
    ps2mct_result_t       out_data_reg, out_data_next;

    logic                 in_take;
    logic                 is_mouse;
    logic                 completes;
    logic                 out_free;
    logic                 advance;
    logic                 left_now;
    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;

    // The limits can always be written.
    assign cfg_ready = 1'b1;

    // A byte in the input register that finishes a packet needs room in the result
    // register; every other byte is consumed at once.
    assign is_mouse      = in_valid_reg && in_aux_reg;
    assign completes     = is_mouse && (state_reg == WAIT_Y);
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && (!completes || out_free);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    assign in_valid_next = in_take || (in_valid_reg && !advance);

    // Cursor moves, worked out two bits wider so both under- and overflow show.
    assign sum_x = $signed({2'b00, pos_x_reg}) + $signed({{(SUM_W-BYTE_W){x_move_reg[BYTE_W-1]}},
                                                          x_move_reg});
    assign sum_y = $signed({2'b00, pos_y_reg}) - $signed({{(SUM_W-BYTE_W){in_byte_reg[BYTE_W-1]}},
                                                          in_byte_reg});
    assign left_now = header_reg[LEFT_BIT];

    always_comb
    begin
        state_next     = state_reg;
        header_next    = header_reg;
        x_move_next    = x_move_reg;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        prev_left_next = prev_left_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;

        if (advance && is_mouse)
        begin
            unique case (state_reg)
                WAIT_HEADER:
                begin
                    // A header without the sync bit is out of step and dropped.
                    if (in_byte_reg[SYNC_BIT])
                    begin
                        header_next = in_byte_reg;
                        state_next  = WAIT_X;
                    end
                end
                WAIT_X:
                begin
                    x_move_next = in_byte_reg;
                    state_next  = WAIT_Y;
                end
                WAIT_Y:
                begin
                    state_next     = WAIT_HEADER;
                    pos_x_next     = clamp_axis(sum_x, max_x_reg);
                    pos_y_next     = clamp_axis(sum_y, max_y_reg);
                    prev_left_next = left_now;
                    out_valid_next = 1'b1;
                    out_data_next.cursor_x     = pos_x_next;
                    out_data_next.cursor_y     = pos_y_next;
                    out_data_next.delta_x      = x_move_reg;
                    out_data_next.delta_y      = in_byte_reg;
                    out_data_next.left_held    = left_now;
                    out_data_next.left_pressed = left_now && !prev_left_reg;
                end
                default:
                begin
                    state_next = WAIT_HEADER;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            state_reg     <= WAIT_HEADER;
            header_reg    <= '0;
            x_move_reg    <= '0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            prev_left_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            state_reg     <= state_next;
            header_reg    <= header_next;
            x_move_reg    <= x_move_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            prev_left_reg <= prev_left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= s_axis_tdata;
            in_aux_reg  <= s_axis_tuser;
        end
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_x_reg <= MAX_X_RESET;
            max_y_reg <= MAX_Y_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (ps2mct_cfg_idx_t'(cfg_index))
                CFG_MAX_X: max_x_reg <= cfg_data;
                CFG_MAX_Y: max_y_reg <= cfg_data;
                default:   max_x_reg <= max_x_reg;
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(TDATA_W-RESULT_W){1'b0}}, out_data_reg};

endmodule

// ===== hdl/ps2mct_checker.sv =====
// Port-level checker for the PS/2 cursor tracker, bound to its top level.
`include "ps2_mouse_cursor_tracker_assert.svh"

module ps2mct_checker
    import ps2mct_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    input  logic                s_axis_tready,
    input  logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    input  logic [TDATA_W-1:0]  m_axis_tdata
);

    // A stalled result holds its contents until it is taken.
    `PS2MCT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // A press is only reported together with the button held down.
    `PS2MCT_ASSERT_NOW(a_press_needs_button, m_axis_tvalid && m_axis_tdata[POS_LEFT_PRESSED], m_axis_tdata[POS_LEFT_BUTTON])

    // An idle output only comes alive once an input transfer has passed the input register into the result register.
    `PS2MCT_ASSERT_NOW(a_result_after_input, $rose(m_axis_tvalid), $past(s_axis_tvalid && s_axis_tready, 2))

endmodule

bind ps2_mouse_cursor_tracker ps2mct_checker u_ps2mct_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
